>>> rtl/lr_pkg.sv
// Shared types and constants of the line rasterizer.
package lr_pkg;

   // Field widths of the request and response channels
   localparam int COORD_W = 6;
   localparam int COLOR_W = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } lr_qstat_type;

   // Packed width of one classified line command:
   // six coordinate-sized fields, two direction bits, the error term and the colour.
   function automatic int cmd_width(input int coord_bits);
      return 7 * coord_bits + 4 + 3 * COLOR_W;
   endfunction

endpackage

>>> rtl/lr_intf.sv
// Request and response channel interfaces of the line rasterizer.
interface lr_req_if import lr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] x_start;
   logic [COORD_W-1:0] y_start;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, x_start, y_start, x_end, y_end, red, green, blue,
                   input ready);
   modport sink   (input valid, x_start, y_start, x_end, y_end, red, green, blue,
                   output ready);
endinterface

interface lr_rsp_if import lr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [COLOR_W-1:0] red_out;
   logic [COLOR_W-1:0] green_out;
   logic [COLOR_W-1:0] blue_out;
   logic               last_pixel;

   modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
                   output ready);
endinterface

>>> rtl/line_rasterizer.sv
// Bresenham line rasterizer: one line request in, one response per pixel out.
// The first pixel of a line passes the command queue, the walker register and the response
// register. The line walker gives one pixel per cycle while the response channel is ready;
// consecutive lines follow without a gap, the two-entry queue holding the next requests.
// Reset (synchronous, active high) empties the queue and drops the walker and response valid.
module line_rasterizer import lr_pkg::*; #(
   parameter int COORD_BITS = 6
) (
   input  logic     clock,
   input  logic     reset,
   lr_req_if.sink   req_if,
   lr_rsp_if.source rsp_if
);

   localparam int CMD_W = cmd_width(COORD_BITS);

   logic             push_valid;
   logic [CMD_W-1:0] push_data;
   logic             pop;
   logic [CMD_W-1:0] pop_data;
   lr_qstat_type     qstat;

   lr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .req        (req_if),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   lr_queue #(.DATA_W(CMD_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .qstat      (qstat)
   );

   lr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp      (rsp_if)
   );

`ifndef SYNTHESIS
   // Queue occupancy never passes its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   // No request taken while the queue is full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_if.ready)
      else $error("request accepted into a full queue");

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

   // Within a line the next pixel follows at once with the same colour
   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last_pixel |=>
         rsp_if.valid && $stable(rsp_if.red_out) && $stable(rsp_if.green_out) &&
         $stable(rsp_if.blue_out))
      else $error("line walk broke off before its last pixel");
`endif

endmodule

>>> rtl/lr_front.sv
// Front end: accepts line requests and works out deltas, directions and initial error.
module lr_front import lr_pkg::*; #(
   parameter int COORD_BITS = 6
) (
   lr_req_if.sink                        req,
   input  lr_qstat_type                  qstat,
   output logic                          push_valid,
   output logic [cmd_width(COORD_BITS)-1:0] push_data
);

   localparam int ERR_W = COORD_BITS + 2;

   typedef struct packed {
      logic [COORD_BITS-1:0]   x;
      logic [COORD_BITS-1:0]   y;
      logic [COORD_BITS-1:0]   x_end;
      logic [COORD_BITS-1:0]   y_end;
      logic [COORD_BITS-1:0]   dx;
      logic [COORD_BITS-1:0]   dy;
      logic                    x_dec;
      logic                    y_dec;
      logic signed [ERR_W-1:0] err;
      color_type               color;
   } cmd_type;

   logic [COORD_BITS-1:0] xs, ys, xe, ye;
   cmd_type               cmd;

   // Take a request whenever the queue has room
   assign req.ready  = !qstat.full;
   assign push_valid = req.valid && !qstat.full;

   // Upper coordinate bits beyond the raster are dropped
   assign xs = req.x_start[COORD_BITS-1:0];
   assign ys = req.y_start[COORD_BITS-1:0];
   assign xe = req.x_end[COORD_BITS-1:0];
   assign ye = req.y_end[COORD_BITS-1:0];

   // Classify: absolute deltas, step directions, starting error term
   always_comb begin
      cmd.x           = xs;
      cmd.y           = ys;
      cmd.x_end       = xe;
      cmd.y_end       = ye;
      cmd.dx          = (xe > xs) ? (xe - xs) : (xs - xe);
      cmd.dy          = (ye > ys) ? (ye - ys) : (ys - ye);
      cmd.x_dec       = !(xs < xe);
      cmd.y_dec       = !(ys < ye);
      if (cmd.dx > cmd.dy) begin
         cmd.err = $signed({2'b00, cmd.dx >> 1});
      end else begin
         cmd.err = -$signed({2'b00, cmd.dy >> 1});
      end
      cmd.color.red   = req.red;
      cmd.color.green = req.green;
      cmd.color.blue  = req.blue;
   end

   assign push_data = cmd;

endmodule

>>> rtl/lr_queue.sv
// Small command FIFO between front end and line walker.
module lr_queue import lr_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output lr_qstat_type      qstat
);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = mem_ff[rd_ptr_ff];
   assign qstat.count = count_ff;
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

>>> rtl/lr_back.sv
// Back end: walks one queued line into the response register, a pixel a cycle while rsp.ready allows.
module lr_back import lr_pkg::*; #(
   parameter int COORD_BITS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lr_qstat_type                     qstat,
   input  logic [cmd_width(COORD_BITS)-1:0] pop_data,
   output logic                             pop,
   lr_rsp_if.source                         rsp
);

   localparam int ERR_W = COORD_BITS + 2;

   typedef struct packed {
      logic [COORD_BITS-1:0]   x;
      logic [COORD_BITS-1:0]   y;
      logic [COORD_BITS-1:0]   x_end;
      logic [COORD_BITS-1:0]   y_end;
      logic [COORD_BITS-1:0]   dx;
      logic [COORD_BITS-1:0]   dy;
      logic                    x_dec;
      logic                    y_dec;
      logic signed [ERR_W-1:0] err;
      color_type               color;
   } cmd_type;

   cmd_type               cur_ff, cur_in, head, stepped;
   logic                  busy_ff, busy_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   color_type             color_ff;
   logic                  last_ff;

   logic                  out_free, emit, at_end, load, x_step, y_step;
   logic signed [ERR_W-1:0] dx_s, dy_s;

   assign head     = pop_data;
   assign out_free = !out_valid_ff || rsp.ready;
   assign emit     = busy_ff && out_free;
   assign at_end   = (cur_ff.x == cur_ff.x_end) && (cur_ff.y == cur_ff.y_end);
   // Next line loads when idle or in the same cycle its predecessor ends
   assign load     = !qstat.empty && (!busy_ff || (emit && at_end));
   assign pop      = load;

   // One Bresenham step
   assign dx_s   = $signed({2'b00, cur_ff.dx});
   assign dy_s   = $signed({2'b00, cur_ff.dy});
   assign x_step = cur_ff.err > -dx_s;
   assign y_step = cur_ff.err < dy_s;

   always_comb begin
      stepped = cur_ff;
      if (x_step) begin
         stepped.x = cur_ff.x_dec ? cur_ff.x - COORD_BITS'(1) : cur_ff.x + COORD_BITS'(1);
      end
      if (y_step) begin
         stepped.y = cur_ff.y_dec ? cur_ff.y - COORD_BITS'(1) : cur_ff.y + COORD_BITS'(1);
      end
      stepped.err = cur_ff.err - (x_step ? dy_s : '0) + (y_step ? dx_s : '0);
   end

   // Walker and response register control
   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = 1'b1;
         cur_in  = head;
      end else if (emit) begin
         busy_in = !at_end;
         cur_in  = stepped;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         px_ff    <= cur_ff.x;
         py_ff    <= cur_ff.y;
         color_ff <= cur_ff.color;
         last_ff  <= at_end;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pixel_x    = COORD_W'(px_ff);
   assign rsp.pixel_y    = COORD_W'(py_ff);
   assign rsp.red_out    = color_ff.red;
   assign rsp.green_out  = color_ff.green;
   assign rsp.blue_out   = color_ff.blue;
   assign rsp.last_pixel = last_ff;

endmodule
